[hdl/cbp_pkg.sv]
// cbp_pkg: shared types and constants for the prefix code bit packer
// item structs, action codes and fixed field widths; no dependencies
package cbp_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int ACC_W  = 64;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_ENCODE = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [7:0]        symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [3:0]        valid_bits;
        logic              last;
    } out_item_t;

    // item waiting between table lookup and packer
    typedef struct packed {
        logic [1:0] action;
        logic       sym_ok;
    } item_ctl_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic [LEN_W-1:0]  code_size;
    } lookup_t;

endpackage

[hdl/prefix_code_bit_packer.sv]
// Table-driven prefix code encoder, MSB first. An item is looked up in the
// code table in the cycle after it is accepted (one synchronous memory read),
// then appended to the pending bits; complete bytes leave through an output
// register, one byte per cycle while m_ready allows. Each item waits until
// fewer than eight bits would be left pending, so an item is taken while the
// last byte of the one before it is sent; a flush first waits while that
// last byte moves into the output register. The first byte of an encode item
// passes through the table read register, the pending bits and the output
// register; a flushed byte goes from the pending bits straight into the
// output register. Code lengths read as zero until loaded: per-entry valid
// bits cleared by reset, so no clearing pass is needed.
// depends on cbp_pkg, cbp_table, cbp_packer
module prefix_code_bit_packer
    import cbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic             accept;
    logic             sym_ok;
    logic [LEN_W-1:0] len_sat;
    logic             consume;
    logic             p1_valid_reg, p1_valid_next;
    item_ctl_t        p1_ctl_reg;
    lookup_t          lookup;

    always_comb begin
        sym_ok  = ({1'b0, s_item.symbol} < 9'(SYMBOL_COUNT));
        len_sat = (s_item.code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                              : s_item.code_length;
        s_ready = !p1_valid_reg || consume;
        accept  = s_valid && s_ready;
        p1_valid_next = accept || (p1_valid_reg && !consume);
    end

    cbp_table #(
        .SYMBOL_COUNT(SYMBOL_COUNT)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (accept && (s_item.action == ACT_LOAD) && sym_ok),
        .rd_en   (accept && (s_item.action == ACT_ENCODE)),
        .symbol  (s_item.symbol),
        .wr_code (s_item.code_bits),
        .wr_len  (len_sat),
        .lookup  (lookup)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_ctl_reg.action <= s_item.action;
            p1_ctl_reg.sym_ok <= sym_ok;
        end
    end

    cbp_packer u_packer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .p1_valid (p1_valid_reg),
        .p1_ctl   (p1_ctl_reg),
        .lookup   (lookup),
        .consume  (consume),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

endmodule

[hdl/cbp_table.sv]
// cbp_table: code table memory (code word and length per symbol)
// one write port, one registered read port; valid bits make unloaded lengths zero
// depends on cbp_pkg
module cbp_table
    import cbp_pkg::*;
#(
    parameter int SYMBOL_COUNT = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic              rd_en,
    input  logic [7:0]        symbol,
    input  logic [CODE_W-1:0] wr_code,
    input  logic [LEN_W-1:0]  wr_len,
    output lookup_t           lookup
);

    localparam int SYM_W = $clog2(SYMBOL_COUNT);

    logic [CODE_W+LEN_W-1:0] mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] vld_reg;
    logic [CODE_W+LEN_W-1:0] rd_data_reg;
    logic                    hit_reg;
    logic [SYM_W-1:0]        addr;

    assign addr = symbol[SYM_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= {wr_code, wr_len};
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[addr] <= 1'b1;
            end
            if (rd_en) begin
                hit_reg <= vld_reg[addr];
            end
        end
    end

    assign lookup.code_word = rd_data_reg[CODE_W+LEN_W-1:LEN_W];
    assign lookup.code_size = hit_reg ? rd_data_reg[LEN_W-1:0] : '0;

endmodule

[hdl/cbp_packer.sv]
// cbp_packer: bit accumulator and byte emitter with output register
// holds pending bits left-aligned in a 64-bit window, sends one byte per cycle while m_ready allows
// depends on cbp_pkg
module cbp_packer
    import cbp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      p1_valid,
    input  item_ctl_t p1_ctl,
    input  lookup_t   lookup,
    output logic      consume,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [ACC_W-1:0]  w_reg, w_next;
    logic [LEN_W-1:0]  t_reg, t_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_item_reg, m_item_next;

    logic              out_free;
    logic              emit;
    logic [LEN_W-1:0]  t_base;
    logic [ACC_W-1:0]  w_base;
    logic              is_flush;
    logic              append;
    logic              flush_out;
    logic [CODE_W-1:0] code_mask;
    logic [ACC_W-1:0]  code_ext;
    logic [LEN_W:0]    shamt;

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        emit     = (t_reg >= LEN_W'(BYTE_W)) && out_free;
        // the last byte of an item and the next item's append share a cycle
        t_base   = emit ? t_reg - LEN_W'(BYTE_W) : t_reg;
        w_base   = emit ? {w_reg[ACC_W-BYTE_W-1:0], {BYTE_W{1'b0}}} : w_reg;
        is_flush = (p1_ctl.action == ACT_FLUSH);
        consume  = p1_valid && (t_base < LEN_W'(BYTE_W))
                   && (!is_flush || (!emit && out_free));
        append   = consume && (p1_ctl.action == ACT_ENCODE) && p1_ctl.sym_ok
                   && (lookup.code_size != '0);
        flush_out = consume && is_flush && (t_reg != '0);

        code_mask = (lookup.code_size >= LEN_W'(CODE_W)) ? '1
                  : ((CODE_W'(1) << lookup.code_size) - CODE_W'(1));
        code_ext  = {{(ACC_W-CODE_W){1'b0}}, lookup.code_word & code_mask};
        // place the code just below the pending bits
        shamt     = (LEN_W+1)'(ACC_W) - {1'b0, t_base} - {1'b0, lookup.code_size};
    end

    always_comb begin
        w_next = w_reg;
        t_next = t_reg;
        if (flush_out) begin
            w_next = '0;
            t_next = '0;
        end else if (append) begin
            w_next = w_base | (code_ext << shamt);
            t_next = t_base + lookup.code_size;
        end else if (emit) begin
            w_next = w_base;
            t_next = t_base;
        end
    end

    always_comb begin
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (emit) begin
            m_valid_next           = 1'b1;
            m_item_next.out_byte   = w_reg[ACC_W-1 -: BYTE_W];
            m_item_next.valid_bits = 4'(BYTE_W);
            m_item_next.last       = (t_reg < LEN_W'(2*BYTE_W));
        end else if (flush_out) begin
            m_valid_next           = 1'b1;
            m_item_next.out_byte   = w_reg[ACC_W-1 -: BYTE_W];
            m_item_next.valid_bits = t_reg[3:0];
            m_item_next.last       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg       <= '0;
            t_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            w_reg       <= w_next;
            t_reg       <= t_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

[hdl/cbp_checker.sv]
// cbp_checker: port-level checks for prefix_code_bit_packer, bound to the top
// depends on cbp_pkg
module cbp_checker
    import cbp_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // only a flushed partial byte may carry fewer than eight bits, and it ends its item
    a_partial_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_item.valid_bits != 4'd8) |-> m_item.last)
        else $error("partial byte not marked last");

    a_bits_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.valid_bits != 4'd0) && (m_item.valid_bits <= 4'd8))
        else $error("valid bit count out of range");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");

endmodule

bind prefix_code_bit_packer cbp_checker u_cbp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

[tb/prefix_code_bit_packer_tb.sv]
// prefix_code_bit_packer_tb: self-checking testbench for the prefix code bit packer
// directed table then random items of all four actions, bytes vs typed rows or local packer
// depends on cbp_pkg and prefix_code_bit_packer
module prefix_code_bit_packer_tb;
    import cbp_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int CODE_LEN_MAX = 32;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 320;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 2000;
    localparam int SHOWN_MAX    = 10;

    typedef struct {
        in_item_t  item;
        bit        typed;
        int        typed_n;
        out_item_t typed_res;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    // local copy of the code table and the partial byte
    logic [CODE_W-1:0] tbl_word [256];
    logic [LEN_W-1:0]  tbl_len [256];
    bit                tbl_loaded [256];
    logic [7:0]        loaded_syms[$];
    logic [7:0]        part_byte;
    logic [2:0]        part_cnt;

    out_item_t due_bytes[$];
    out_item_t want_byte;
    dir_row_t  dir_rows[$];
    int        bad_bytes = 0;
    int        stall_cnt = 0;
    int        idle_pct = 10;
    bit        hold_req = 1'b0;
    bit        calm = 1'b0;

    prefix_code_bit_packer uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always #6 aclk = ~aclk;

    // bytes that one item pushes out of the packer, state updated in place
    function automatic void pack_item(input in_item_t it, ref out_item_t res[$]);
        logic [LEN_W-1:0] clen;
        logic [63:0]      acc;
        int               total;
        out_item_t        o;
        case (it.action)
            ACT_LOAD: begin
                clen = (it.code_length > CODE_LEN_MAX) ? LEN_W'(CODE_LEN_MAX) : it.code_length;
                tbl_word[it.symbol] = it.code_bits;
                tbl_len[it.symbol]  = clen;
                if (!tbl_loaded[it.symbol]) begin
                    tbl_loaded[it.symbol] = 1'b1;
                    loaded_syms.push_back(it.symbol);
                end
            end
            ACT_ENCODE: begin
                clen = tbl_len[it.symbol];
                if (clen != 0) begin
                    acc = {56'd0, part_byte} >> (8 - part_cnt);
                    acc = (acc << clen)
                        | ({32'd0, tbl_word[it.symbol]} & ((64'd1 << clen) - 64'd1));
                    total = part_cnt + clen;
                    while (total >= 8) begin
                        total -= 8;
                        o.out_byte   = 8'(acc >> total);
                        o.valid_bits = 4'd8;
                        o.last       = (total < 8);
                        res.push_back(o);
                    end
                    part_cnt  = 3'(total);
                    part_byte = (total == 0) ? 8'd0 : 8'(acc << (8 - total));
                end
            end
            ACT_FLUSH: begin
                if (part_cnt != 0) begin
                    o.out_byte   = part_byte;
                    o.valid_bits = 4'(part_cnt);
                    o.last       = 1'b1;
                    res.push_back(o);
                    part_byte = 8'd0;
                    part_cnt  = 3'd0;
                end
            end
            default: ;
        endcase
    endfunction

    // want_n < 0: row is checked against the local packer
    function automatic void add_row(input logic [1:0] act, input logic [7:0] sym,
                                    input logic [31:0] bits, input logic [5:0] len,
                                    input int want_n = -1, input logic [7:0] ob = 8'd0,
                                    input logic [3:0] vb = 4'd0);
        dir_row_t r;
        r.item      = '{action: act, symbol: sym, code_bits: bits, code_length: len};
        r.typed     = (want_n >= 0);
        r.typed_n   = want_n;
        r.typed_res = '{out_byte: ob, valid_bits: vb, last: 1'b1};
        dir_rows.push_back(r);
    endfunction

    function automatic in_item_t rand_item();
        in_item_t    it;
        int unsigned pick;
        it   = {16'($urandom), $urandom};
        pick = $urandom_range(0, 99);
        if (pick < 15 || loaded_syms.size() == 0) begin
            it.action = ACT_LOAD;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                it.code_length = 6'($urandom_range(1, 12));
            else if (pick < 85)
                it.code_length = 6'($urandom_range(13, 32));
            else if (pick < 93)
                it.code_length = 6'($urandom_range(33, 63));
            else
                it.code_length = '0;
        end else if (pick < 80) begin
            // only symbols whose code word was written
            it.action = ACT_ENCODE;
            it.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        end else if (pick < 95) begin
            it.action = ACT_FLUSH;
        end else begin
            it.action = ACT_NONE;
        end
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input bit typed, input int typed_n,
                             input out_item_t typed_res);
        out_item_t got[$];
        @(negedge aclk);
        s_item  = it;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pack_item(it, got);
        if (typed) begin
            if (typed_n > 0) due_bytes.push_back(typed_res);
        end else begin
            foreach (got[i]) due_bytes.push_back(got[i]);
        end
    endtask

    task automatic idle_gap(input int n);
        @(negedge aclk);
        s_valid = 1'b0;
        s_item  = {16'($urandom), $urandom};
        repeat (n - 1) @(negedge aclk);
    endtask

    // sender
    initial begin
        in_item_t it;
        int       done;
        bit       held;
        bit       paused;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item  = '0;
        part_byte = 8'd0;
        part_cnt  = 3'd0;
        foreach (tbl_len[i]) begin
            tbl_len[i]    = '0;
            tbl_loaded[i] = 1'b0;
        end

        add_row(ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  0);           // flush, nothing pending
        add_row(ACT_NONE,   8'hff, 32'hffff_ffff, 6'd63, 0);
        add_row(ACT_LOAD,   8'h41, 32'h0000_00a5, 6'd8,  0);
        add_row(ACT_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  1, 8'ha5, 4'd8);
        add_row(ACT_LOAD,   8'hff, 32'hffff_ffff, 6'd32, 0);
        add_row(ACT_LOAD,   8'h00, 32'h0000_0000, 6'd32, 0);
        add_row(ACT_LOAD,   8'h10, 32'h0000_0001, 6'd1,  0);
        add_row(ACT_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  0);
        add_row(ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 8'h80, 4'd1);
        add_row(ACT_ENCODE, 8'hff, 32'h0000_0000, 6'd0);
        add_row(ACT_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
        add_row(ACT_LOAD,   8'h20, 32'h0000_007f, 6'd7,  0);
        add_row(ACT_ENCODE, 8'h20, 32'h0000_0000, 6'd0,  0);
        add_row(ACT_ENCODE, 8'hff, 32'h0000_0000, 6'd0);              // seven pending plus 32
        add_row(ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 8'hfe, 4'd7);
        add_row(ACT_LOAD,   8'h30, 32'hdead_beef, 6'd63, 0);           // length saturates
        add_row(ACT_ENCODE, 8'h10, 32'h0000_0000, 6'd0,  0);
        add_row(ACT_ENCODE, 8'h30, 32'h0000_0000, 6'd0);
        add_row(ACT_LOAD,   8'h40, 32'h1234_5678, 6'd0,  0);           // zero-length entry
        add_row(ACT_ENCODE, 8'h40, 32'h0000_0000, 6'd0,  0);
        add_row(ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0);
        add_row(ACT_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  0);
        add_row(ACT_LOAD,   8'h41, 32'h0000_0000, 6'd33, 0);
        add_row(ACT_ENCODE, 8'h41, 32'h0000_0000, 6'd0);
        add_row(ACT_NONE,   8'h00, 32'h0000_0000, 6'd0,  0);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].typed_n,
                      dir_rows[i].typed_res);
            if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 14));
        end

        done   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (done < RANDOM_ITEMS) begin
            it = rand_item();
            send_item(it, 1'b0, 0, '0);
            if (it.action != ACT_NONE) begin
                done++;
                if (done % 40 == 0) begin
                    case ($urandom_range(0, 2))
                        0: idle_pct = 0;
                        1: idle_pct = 10;
                        default: idle_pct = 30;
                    endcase
                end
            end
            if (done >= 300) calm = 1'b1;
            if (done >= 80 && !held) begin
                // receiver stops for a long while, keep offering items
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (done >= 200 && !paused) begin
                paused = 1'b1;
                @(negedge aclk);
                s_valid = 1'b0;
                while (due_bytes.size() != 0) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
                idle_gap($urandom_range(1, 14));
            end
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (due_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (bad_bytes == 0 && due_bytes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // receiver
    initial begin
        int rcv_pct;
        int ticks;
        bit hold_done;
        m_ready   = 1'b0;
        rcv_pct   = 20;
        ticks     = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            ticks++;
            if (ticks % 50 == 0) rcv_pct = $urandom_range(0, 2) * 20;
            if (hold_req && !hold_done) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (!calm && aresetn && $urandom_range(0, 99) < rcv_pct) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // byte checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_bytes.size() == 0) begin
                bad_bytes++;
                if (bad_bytes <= SHOWN_MAX)
                    $display("unexpected byte: out_byte %h valid_bits %0d last %0b",
                             m_item.out_byte, m_item.valid_bits, m_item.last);
            end else begin
                want_byte = due_bytes.pop_front();
                if (m_item.out_byte !== want_byte.out_byte
                        || m_item.valid_bits !== want_byte.valid_bits
                        || m_item.last !== want_byte.last) begin
                    bad_bytes++;
                    if (bad_bytes <= SHOWN_MAX)
                        $display("byte mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                                 want_byte.out_byte, want_byte.valid_bits, want_byte.last,
                                 m_item.out_byte, m_item.valid_bits, m_item.last);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cnt = 0;
        else
            stall_cnt++;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
